// File: rtl/core/positional_list_buffer_assert.svh
// Assertion macros used by the list buffer top level.
// Expects signals named clk and rst in the module that uses them.
`ifndef POSITIONAL_LIST_BUFFER_ASSERT_SVH
`define POSITIONAL_LIST_BUFFER_ASSERT_SVH
`ifndef SYNTHESIS
// Checks a property on every rising edge outside reset.
`define PLB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checks that a consequent holds in the cycle after an antecedent.
`define PLB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PLB_ASSERT(label, prop, msg)
`define PLB_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: rtl/core/plb_pkg.sv
// Package for the positional list buffer: sizes, codes and the cell command.
// Used by the interfaces, the cell, the control decoder and the top level.
package plb_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int POS_W      = 8;
  localparam int CMP_W      = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int KIND_W     = 3;
  localparam int VALUE_W    = 32;
  localparam int LEN_W      = 7;
  localparam int STATUS_W   = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_INS_FRONT = 3'd0,
    KIND_INS_BACK  = 3'd1,
    KIND_INS_POS   = 3'd2,
    KIND_DEL_FRONT = 3'd3,
    KIND_DEL_BACK  = 3'd4,
    KIND_DEL_POS   = 3'd5,
    KIND_SEARCH    = 3'd6
  } plb_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_EMPTY   = 2'd1,
    STATUS_INVALID = 2'd2,
    STATUS_FULL    = 2'd3
  } plb_status_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2,
    CELL_SRCH = 2'd3
  } plb_cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_EXEC   = 2'd1,
    ST_REDUCE = 2'd2
  } plb_state_t;

  typedef struct packed {
    plb_cell_op_t            op;
    logic [IDX_W-1:0]        idx;
    logic [DATA_WIDTH-1:0]   data;
  } plb_cmd_t;

  // Sign-extend the 32-bit input word and keep the low DATA_WIDTH bits.
  function automatic logic [DATA_WIDTH-1:0] to_data(input logic signed [VALUE_W-1:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    return w[DATA_WIDTH-1:0];
  endfunction

endpackage

// File: rtl/core/plb_ifs.sv
// Request and response channel interfaces of the positional list buffer.
// Depends on plb_pkg for field widths.
interface plb_req_if;
  import plb_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [KIND_W-1:0]          kind;
  logic signed [VALUE_W-1:0]  value;
  logic [POS_W-1:0]           position;

  modport source (output valid, kind, value, position, input ready);
  modport sink   (input valid, kind, value, position, output ready);
endinterface

interface plb_rsp_if;
  import plb_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic                  found;
  logic [LEN_W-1:0]      length;
  logic                  is_empty;

  modport source (output valid, status, found, length, is_empty, input ready);
  modport sink   (input valid, status, found, length, is_empty, output ready);
endinterface

// File: rtl/core/positional_list_buffer.sv
// Top level of the positional list buffer: request register, sequencer,
// the chain of storage cells and the response register. Depends on plb_pkg,
// plb_ifs, plb_ctrl, plb_cell and the assertion macro header.
//
//   Channel   Role   Carries
//   req       sink   kind, value, position (one request word)
//   rsp       source status, found, length, is_empty (one response word)
//
// Each request passes through three steps: the accepting edge, an edge on which the
// whole cell chain shifts or compares in parallel, and an edge on which the
// per-cell match flags are ORed into the response register. A new request
// may be taken every third cycle, set by that three-step sequencer.
// Reset clears the entry count, the sequencer and the response valid; the
// cell contents stay undefined until written and are never read beyond the
// count. A stalled response word only holds the sequencer in its last step;
// the next request is still taken while a finished word waits.
`include "positional_list_buffer_assert.svh"

module positional_list_buffer (
  input logic clk,
  input logic rst,
  plb_req_if.sink   req,
  plb_rsp_if.source rsp
);
  import plb_pkg::*;

  plb_state_t state;
  plb_state_t state_next;

  // Captured request word.
  logic [KIND_W-1:0]         req_kind;
  logic signed [VALUE_W-1:0] req_value;
  logic [POS_W-1:0]          req_position;

  // Number of live entries; entry 0 is the front of the list.
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  plb_cmd_t    cmd;
  plb_status_t exec_status;
  plb_status_t status_q;

  logic [DATA_WIDTH-1:0] cell_entry [CAPACITY];
  logic [CAPACITY-1:0]   cell_match;

  logic req_fire;
  logic out_free;
  logic exec;
  logic load_rsp;

  logic [CMP_W-1:0] count_w;

  assign req_fire = req.valid && req.ready;
  assign out_free = !rsp.valid || rsp.ready;
  assign exec     = state == ST_EXEC;
  assign load_rsp = (state == ST_REDUCE) && out_free;
  assign count_w  = CMP_W'(count);

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (req_fire) state_next = ST_EXEC;
      ST_EXEC:   state_next = ST_REDUCE;
      ST_REDUCE: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    unique case (state)
      ST_IDLE: req.ready = 1'b1;
      default: req.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      req_kind     <= req.kind;
      req_value    <= req.value;
      req_position <= req.position;
    end
  end

  plb_ctrl u_ctrl (
    .exec     (exec),
    .kind     (req_kind),
    .value    (req_value),
    .position (req_position),
    .cnt      (count),
    .cmd      (cmd),
    .status   (exec_status),
    .cnt_next (count_next)
  );

  // The status is kept from the execute edge until the response is loaded.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      status_q <= exec_status;
    end
  end

  // The cell chain. Each cell sees its left neighbor for inserts and its
  // right neighbor for deletes; the ends are tied to harmless values.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_in;
    logic [DATA_WIDTH-1:0] right_in;

    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_inner_l
      assign left_in = cell_entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_in = cell_entry[i];
    end else begin : g_inner_r
      assign right_in = cell_entry[i+1];
    end

    plb_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .cnt         (count),
      .cell_idx    (IDX_W'(i)),
      .left_entry  (left_in),
      .right_entry (right_in),
      .entry       (cell_entry[i]),
      .match       (cell_match[i])
    );
  end

  // Response register. Match flags are refreshed only by a search and hold
  // their last value otherwise, so found is gated by the captured kind and
  // is zero for every other kind.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load_rsp) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp.status   <= status_q;
      rsp.found    <= (req_kind == KIND_SEARCH) && (|cell_match);
      rsp.length   <= count_w[LEN_W-1:0];
      rsp.is_empty <= count == '0;
    end
  end

  `PLB_ASSERT(a_count_bound, count_w <= CMP_W'(CAPACITY), "entry count above capacity")
  `PLB_ASSERT_NEXT(a_count_only_exec, state != ST_EXEC, count == $past(count), "count moved outside execute")
  `PLB_ASSERT_NEXT(a_full_no_change, exec && exec_status == STATUS_FULL, count == $past(count), "full insert changed count")
  `PLB_ASSERT_NEXT(a_rsp_loaded, load_rsp, rsp.valid, "response not loaded")

endmodule

// File: rtl/core/plb_cell.sv
// One storage cell of the list chain: holds one entry and its search match.
// Depends on plb_pkg for the command struct and sizes.
module plb_cell (
  input  logic                           clk,
  input  plb_pkg::plb_cmd_t              cmd,
  input  logic [plb_pkg::CNT_W-1:0]      cnt,
  input  logic [plb_pkg::IDX_W-1:0]      cell_idx,
  input  logic [plb_pkg::DATA_WIDTH-1:0] left_entry,
  input  logic [plb_pkg::DATA_WIDTH-1:0] right_entry,
  output logic [plb_pkg::DATA_WIDTH-1:0] entry,
  output logic                           match
);
  import plb_pkg::*;

  logic [DATA_WIDTH-1:0] entry_next;
  logic                  in_list;

  assign in_list = CNT_W'(cell_idx) < cnt;

  always_comb begin
    entry_next = entry;
    case (cmd.op)
      CELL_INS: begin
        if (cell_idx == cmd.idx) begin
          entry_next = cmd.data;
        end else if (cell_idx > cmd.idx) begin
          entry_next = left_entry;
        end
      end
      CELL_DEL: begin
        if (cell_idx >= cmd.idx) begin
          entry_next = right_entry;
        end
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  // The match flag is refreshed only by a search and holds until the next
  // one, so it survives while the response word is stalled.
  always_ff @(posedge clk) begin
    entry <= entry_next;
    if (cmd.op == CELL_SRCH) begin
      match <= in_list && (entry == cmd.data);
    end
  end

endmodule

// File: rtl/core/plb_ctrl.sv
// Request decoder: range checks, status and the command sent down the cells.
// Depends on plb_pkg for codes, sizes and the command struct.
module plb_ctrl (
  input  logic                              exec,
  input  logic [plb_pkg::KIND_W-1:0]        kind,
  input  logic signed [plb_pkg::VALUE_W-1:0] value,
  input  logic [plb_pkg::POS_W-1:0]         position,
  input  logic [plb_pkg::CNT_W-1:0]         cnt,
  output plb_pkg::plb_cmd_t                 cmd,
  output plb_pkg::plb_status_t              status,
  output logic [plb_pkg::CNT_W-1:0]         cnt_next
);
  import plb_pkg::*;

  logic [CMP_W-1:0] pos_w;
  logic [CMP_W-1:0] cnt_w;
  logic [CMP_W-1:0] pos_m1;
  logic             full;
  logic             empty;

  assign pos_w  = CMP_W'(position);
  assign cnt_w  = CMP_W'(cnt);
  assign pos_m1 = pos_w - CMP_W'(1);
  assign full   = cnt_w >= CMP_W'(CAPACITY);
  assign empty  = cnt == '0;

  always_comb begin
    cmd.op   = CELL_HOLD;
    cmd.idx  = '0;
    cmd.data = to_data(value);
    status   = STATUS_OK;
    cnt_next = cnt;
    if (exec) begin
      unique case (kind)
        KIND_INS_FRONT: begin
          if (full) begin
            status = STATUS_FULL;
          end else begin
            cmd.op   = CELL_INS;
            cnt_next = cnt + CNT_W'(1);
          end
        end
        KIND_INS_BACK: begin
          if (full) begin
            status = STATUS_FULL;
          end else begin
            cmd.op   = CELL_INS;
            cmd.idx  = cnt_w[IDX_W-1:0];
            cnt_next = cnt + CNT_W'(1);
          end
        end
        KIND_INS_POS: begin
          if (pos_w == '0 || pos_w > cnt_w + CMP_W'(1)) begin
            status = STATUS_INVALID;
          end else if (full) begin
            status = STATUS_FULL;
          end else begin
            cmd.op   = CELL_INS;
            cmd.idx  = pos_m1[IDX_W-1:0];
            cnt_next = cnt + CNT_W'(1);
          end
        end
        KIND_DEL_FRONT: begin
          if (empty) begin
            status = STATUS_EMPTY;
          end else begin
            cmd.op   = CELL_DEL;
            cnt_next = cnt - CNT_W'(1);
          end
        end
        KIND_DEL_BACK: begin
          // The tail entry simply falls out of range; no cell moves.
          if (empty) begin
            status = STATUS_EMPTY;
          end else begin
            cnt_next = cnt - CNT_W'(1);
          end
        end
        KIND_DEL_POS: begin
          if (pos_w == '0 || pos_w > cnt_w) begin
            status = STATUS_INVALID;
          end else begin
            cmd.op   = CELL_DEL;
            cmd.idx  = pos_m1[IDX_W-1:0];
            cnt_next = cnt - CNT_W'(1);
          end
        end
        KIND_SEARCH: begin
          cmd.op = CELL_SRCH;
        end
        default: begin
          status = STATUS_OK;
        end
      endcase
    end
  end

endmodule

// File: bench/tb.sv
// Testbench for positional_list_buffer: random and directed list requests
// checked word by word against a predictor of the list kept in the bench.
// Depends on plb_pkg, the channel interfaces in plb_ifs and the RTL top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import plb_pkg::*;

  // Kind code 7 has no operation behind it; the block must answer it with
  // an OK status and leave the list alone.
  localparam logic [KIND_W-1:0] KIND_SPARE = 3'd7;

  // Bias of a burst of random traffic.
  localparam int MIX_FILL   = 0;
  localparam int MIX_DRAIN  = 1;
  localparam int MIX_EVEN   = 2;
  localparam int MIX_INSERT = 3;

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   position;
  } list_req_t;

  typedef struct {
    plb_status_t        status;
    logic               found;
    logic [LEN_W-1:0]   length;
    logic               is_empty;
  } list_rsp_t;

  logic clk;
  logic rst;

  plb_req_if req_ch ();
  plb_rsp_if rsp_ch ();

  positional_list_buffer dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Requests waiting to be offered; the head is the word on the bus while
  // valid is high.
  list_req_t   pending_reqs[$];
  // Responses the list must produce, oldest first.
  list_rsp_t   expected_rsps[$];

  // Shadow copy of the list contents and its length.
  logic [DATA_WIDTH-1:0] shadow_entries [CAPACITY];
  int unsigned           shadow_len;

  int          send_idle_pct;
  int          recv_idle_pct;
  int          requests_taken;
  int          hold_at = -1;
  int          hold_left;
  bit          hold_done;
  int          n_fail;
  list_rsp_t   want;

  // A few values that recur, so that searches hit and duplicates appear.
  logic [VALUE_W-1:0] value_pool [8] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
                                         32'hffff_ffff, 32'h0000_0005, 32'h0000_0011,
                                         32'h1234_5678, 32'hdead_beef};

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Apply one request to the shadow list and return the response it must
  // produce. Inserts shift the later entries toward the back, deletes pull
  // them toward the front, exactly as the cell chain does.
  function automatic list_rsp_t apply_list_op(input list_req_t r);
    list_rsp_t             res;
    logic [63:0]           ext;
    logic [DATA_WIDTH-1:0] v;
    int                    slot;
    int                    drop;
    ext        = {{32{r.value[VALUE_W-1]}}, r.value};
    v          = ext[DATA_WIDTH-1:0];
    res.status = STATUS_OK;
    res.found  = 1'b0;
    slot       = -1;
    drop       = -1;
    case (r.kind)
      KIND_INS_FRONT: begin
        if (shadow_len >= CAPACITY) res.status = STATUS_FULL;
        else slot = 0;
      end
      KIND_INS_BACK: begin
        if (shadow_len >= CAPACITY) res.status = STATUS_FULL;
        else slot = shadow_len;
      end
      KIND_INS_POS: begin
        // The range check wins over the full check.
        if (r.position < 1 || r.position > shadow_len + 1) res.status = STATUS_INVALID;
        else if (shadow_len >= CAPACITY) res.status = STATUS_FULL;
        else slot = r.position - 1;
      end
      KIND_DEL_FRONT: begin
        if (shadow_len == 0) res.status = STATUS_EMPTY;
        else drop = 0;
      end
      KIND_DEL_BACK: begin
        if (shadow_len == 0) res.status = STATUS_EMPTY;
        else drop = shadow_len - 1;
      end
      KIND_DEL_POS: begin
        if (r.position < 1 || r.position > shadow_len) res.status = STATUS_INVALID;
        else drop = r.position - 1;
      end
      KIND_SEARCH: begin
        for (int i = 0; i < shadow_len; i++) begin
          if (shadow_entries[i] == v) res.found = 1'b1;
        end
      end
      default: ;
    endcase
    if (slot >= 0) begin
      for (int i = shadow_len; i > slot; i--) shadow_entries[i] = shadow_entries[i-1];
      shadow_entries[slot] = v;
      shadow_len++;
    end
    if (drop >= 0) begin
      for (int i = drop; i + 1 < shadow_len; i++) shadow_entries[i] = shadow_entries[i+1];
      shadow_len--;
    end
    res.length   = shadow_len[LEN_W-1:0];
    res.is_empty = (shadow_len == 0);
    return res;
  endfunction

  // Request driver. A word on the bus stays put until the block takes it;
  // only then may the next one go up, after an optional idle gap. Each
  // accepted word is run through the predictor right away.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_rsps.push_back(apply_list_op(pending_reqs.pop_front()));
        requests_taken <= requests_taken + 1;
      end
      if (req_ch.valid && !req_ch.ready) begin
        // Holding the offered word.
      end else if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req_ch.valid    <= 1'b1;
        req_ch.kind     <= pending_reqs[0].kind;
        req_ch.value    <= pending_reqs[0].value;
        req_ch.position <= pending_reqs[0].position;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off: once a set number of requests has been taken,
  // the receiver stops for a long stretch while the sender keeps offering,
  // so that the finished word backs up and the block refuses new requests.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && requests_taken == hold_at) begin
      hold_left <= 250;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Response monitor: every accepted word is compared field by field with
  // the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          $error("response word with no request outstanding");
          n_fail++;
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
            n_fail++;
          end
          if (rsp_ch.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, rsp_ch.found);
            n_fail++;
          end
          if (rsp_ch.length !== want.length) begin
            $error("length: expected %0d, got %0d", want.length, rsp_ch.length);
            n_fail++;
          end
          if (rsp_ch.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, rsp_ch.is_empty);
            n_fail++;
          end
        end
      end
      rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic queue_word(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value,
                            input logic [POS_W-1:0] position);
    list_req_t r;
    r.kind     = kind;
    r.value    = value;
    r.position = position;
    pending_reqs.push_back(r);
  endtask

  // Random traffic in bursts. Each burst leans toward filling, draining or
  // neither, so the list sweeps between empty and full many times. The
  // first burst may be forced to a given lean.
  task automatic queue_random_traffic(input int count, input int first_mix, input int first_len);
    list_req_t r;
    int        left;
    int        burst;
    int        mix;
    int        roll;
    left  = count;
    burst = first_len;
    mix   = first_mix;
    while (left > 0) begin
      if (burst > left) burst = left;
      repeat (burst) begin
        roll = $urandom_range(99);
        case (mix)
          MIX_FILL: begin
            if (roll < 80) r.kind = 3'($urandom_range(KIND_INS_FRONT, KIND_INS_POS));
            else if (roll < 90) r.kind = KIND_SEARCH;
            else if (roll < 98) r.kind = 3'($urandom_range(KIND_DEL_FRONT, KIND_DEL_POS));
            else r.kind = KIND_SPARE;
          end
          MIX_DRAIN: begin
            if (roll < 75) r.kind = 3'($urandom_range(KIND_DEL_FRONT, KIND_DEL_POS));
            else if (roll < 85) r.kind = KIND_SEARCH;
            else if (roll < 98) r.kind = 3'($urandom_range(KIND_INS_FRONT, KIND_INS_POS));
            else r.kind = KIND_SPARE;
          end
          MIX_INSERT: begin
            // Front and back inserts land unless the list is full, which drives the list to full.
            if (roll < 85) r.kind = 3'($urandom_range(KIND_INS_FRONT, KIND_INS_BACK));
            else r.kind = KIND_INS_POS;
          end
          default: begin
            if (roll < 2) r.kind = KIND_SPARE;
            else r.kind = 3'($urandom_range(KIND_INS_FRONT, KIND_SEARCH));
          end
        endcase
        if ($urandom_range(1) == 0) r.value = value_pool[$urandom_range(7)];
        else r.value = $urandom();
        roll = $urandom_range(99);
        if (roll < 75) r.position = 8'($urandom_range(1, CAPACITY + 2));
        else if (roll < 85) r.position = '0;
        else r.position = 8'($urandom_range(255));
        pending_reqs.push_back(r);
      end
      left  -= burst;
      burst  = $urandom_range(30, 80);
      mix    = $urandom_range(MIX_FILL, MIX_EVEN);
    end
  endtask

  initial begin
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.kind     = '0;
    req_ch.value    = '0;
    req_ch.position = '0;
    rsp_ch.ready    = 1'b0;
    send_idle_pct   = 25;
    recv_idle_pct   = 80;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part. An empty list first: both end deletes report empty,
    // positional deletes and bad positional inserts report invalid.
    queue_word(KIND_DEL_FRONT, 32'h0, 8'd0);
    queue_word(KIND_DEL_BACK,  32'h0, 8'd0);
    queue_word(KIND_DEL_POS,   32'h0, 8'd1);
    queue_word(KIND_DEL_POS,   32'h0, 8'd0);
    queue_word(KIND_SEARCH,    32'h0, 8'd0);
    queue_word(KIND_INS_POS,   32'h1, 8'd0);
    queue_word(KIND_INS_POS,   32'h1, 8'd2);
    // Insert at position 1 must behave as a single insert at the front.
    queue_word(KIND_INS_POS,   32'h7fff_ffff, 8'd1);
    queue_word(KIND_INS_FRONT, 32'h8000_0000, 8'd255);
    queue_word(KIND_INS_BACK,  32'h0000_0000, 8'd0);
    queue_word(KIND_INS_BACK,  32'hffff_ffff, 8'd0);
    // One past the last entry is still a legal insert position.
    queue_word(KIND_INS_POS,   32'h1234_5678, 8'd5);
    queue_word(KIND_INS_POS,   32'ha5a5_a5a5, 8'd3);
    queue_word(KIND_INS_POS,   32'h5a5a_5a5a, 8'd255);
    queue_word(KIND_SEARCH,    32'h8000_0000, 8'd0);
    queue_word(KIND_SEARCH,    32'h7fff_ffff, 8'd0);
    queue_word(KIND_SEARCH,    32'h5555_5555, 8'd0);
    queue_word(KIND_SPARE,     32'hffff_ffff, 8'd255);
    queue_word(KIND_DEL_POS,   32'h0, 8'd255);
    queue_word(KIND_DEL_POS,   32'h0, 8'd7);
    queue_word(KIND_DEL_POS,   32'h0, 8'd6);
    queue_word(KIND_DEL_POS,   32'h0, 8'd2);
    queue_word(KIND_DEL_FRONT, 32'h0, 8'd0);
    queue_word(KIND_DEL_BACK,  32'h0, 8'd0);
    queue_word(KIND_SEARCH,    32'hffff_ffff, 8'd0);

    // Sender mostly busy, receiver mostly stalled.
    queue_random_traffic(200, MIX_FILL, 60);
    wait (pending_reqs.size() == 0);
    @(negedge clk);

    // Sender mostly idle, receiver mostly ready.
    send_idle_pct = 80;
    recv_idle_pct = 25;
    queue_random_traffic(200, MIX_EVEN, 50);
    wait (pending_reqs.size() == 0);
    @(negedge clk);

    // Back to back. The run opens with a fill toward full, and the long
    // receiver hold-off lands inside it.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_at       = requests_taken + 20;
    queue_random_traffic(200, MIX_INSERT, 75);

    wait (pending_reqs.size() == 0);
    wait (expected_rsps.size() == 0);
    repeat (20) @(posedge clk);
    if (expected_rsps.size() != 0) begin
      $error("%0d response words never arrived", expected_rsps.size());
      n_fail++;
    end
    if (n_fail == 0) begin
      $display("positional_list_buffer: match");
    end else begin
      $display("positional_list_buffer: mismatch");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("positional_list_buffer: mismatch");
    $finish;
  end

endmodule
